FILE: design/palette_rgb565_rotate_converter_assert.svh
// assertion macros for the palette converter checker
`ifndef PALETTE_RGB565_ROTATE_CONVERTER_ASSERT_SVH
`define PALETTE_RGB565_ROTATE_CONVERTER_ASSERT_SVH

// property checked on the rising clock, off while reset is asserted
`define PRRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// signal holds its value in the cycle after the condition
`define PRRC_ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

FILE: design/palrot_pkg.sv
// shared widths, constants and types of the palette converter
`default_nettype none

package palrot_pkg;

	localparam int IndexWidth    = 8;
	localparam int ByteWidth     = 8;
	localparam int ColorWidth    = 16;
	localparam int RowWidth      = 8;
	localparam int ColWidth      = 9;
	localparam int AddrWidth     = 19;
	localparam int StrideWidth   = 11;
	localparam int MarginWidth   = 10;
	localparam int RowSumWidth   = 11;
	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 11;
	localparam int PaletteDepth  = 256;

	localparam logic [CfgIndexWidth-1:0] RegPanelStride  = 2'd0;
	localparam logic [CfgIndexWidth-1:0] RegColumnMargin = 2'd1;

	localparam logic [StrideWidth-1:0] StrideReset = 11'd240;
	localparam logic [MarginWidth-1:0] MarginReset = 10'd20;

	localparam logic KindPalette = 1'b0;
	localparam logic KindPixel   = 1'b1;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_en_t;

endpackage

`default_nettype wire

FILE: design/palette_rgb565_rotate_converter.sv
// top level: paletted pixel to rgb565 with 90 degree rotated panel address
// pipeline: three register stages s1, s2 and s3, a pixel's result is offered from s3
// throughput: one item per cycle, input stalls only while the output is held back; the
// palette is read at the transfer edge, the address path mirrors, multiplies and adds
// palette writes give no result. reset clears the valid bits and sets stride 240 and
// margin 20; palette entries are undefined until written, no clearing pass
`default_nettype none

module palette_rgb565_rotate_converter
	import palrot_pkg::*;
#(
	parameter int SRC_WIDTH = 320
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     kind,
	input  wire logic [IndexWidth-1:0]    color_index,
	input  wire logic [ByteWidth-1:0]     red,
	input  wire logic [ByteWidth-1:0]     green,
	input  wire logic [ByteWidth-1:0]     blue,
	input  wire logic [RowWidth-1:0]      src_row,
	input  wire logic [ColWidth-1:0]      src_col,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic      [AddrWidth-1:0]     pixel_address,
	output logic      [ColorWidth-1:0]    pixel_color,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CfgIndexWidth-1:0] cfg_index,
	input  wire logic [CfgDataWidth-1:0]  cfg_data
);

	logic [StrideWidth-1:0] stride_q;
	logic [MarginWidth-1:0] margin_q;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   valid_s3;
	logic [ColorWidth-1:0]  color_s1;
	logic [ColorWidth-1:0]  color_s2;
	logic [ColorWidth-1:0]  color_s3;
	logic                   in_xfer;
	pipe_en_t               en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= StrideReset;
			margin_q <= MarginReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegPanelStride: begin
					stride_q <= cfg_data;
				end
				RegColumnMargin: begin
					margin_q <= cfg_data[MarginWidth-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		en.en_s3 = !valid_s3 || out_ready;
		en.en_s2 = !valid_s2 || en.en_s3;
		en.en_s1 = !valid_s1 || en.en_s2;
	end

	assign in_ready = en.en_s1;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.en_s1) begin
				valid_s1 <= in_xfer && (kind == KindPixel);
			end
			if (en.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	palrot_palette u_palette (
		.clk     (clk),
		.wr_en   (in_xfer && (kind == KindPalette)),
		.wr_idx  (color_index),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.rd_en   (en.en_s1),
		.rd_idx  (color_index),
		.rd_data (color_s1)
	);

	palrot_addr #(
		.SRC_WIDTH (SRC_WIDTH)
	) u_addr (
		.clk     (clk),
		.en      (en),
		.src_row (src_row),
		.src_col (src_col),
		.stride  (stride_q),
		.margin  (margin_q),
		.addr_s3 (pixel_address)
	);

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			color_s2 <= color_s1;
		end
		if (en.en_s3) begin
			color_s3 <= color_s2;
		end
	end

	assign out_valid   = valid_s3;
	assign pixel_color = color_s3;

endmodule

`default_nettype wire

FILE: design/palrot_palette.sv
// palette memory with rgb565 packing on write and registered read
`default_nettype none

module palrot_palette
	import palrot_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [IndexWidth-1:0] wr_idx,
	input  wire logic [ByteWidth-1:0]  red,
	input  wire logic [ByteWidth-1:0]  green,
	input  wire logic [ByteWidth-1:0]  blue,
	input  wire logic                  rd_en,
	input  wire logic [IndexWidth-1:0] rd_idx,
	output logic      [ColorWidth-1:0] rd_data
);

	logic [ColorWidth-1:0] mem [PaletteDepth];
	logic [ColorWidth-1:0] packed_color;

	assign packed_color = {red[7:3], green[7:2], blue[7:3]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= packed_color;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

FILE: design/palrot_addr.sv
// rotated panel address pipeline: mirror column, multiply by stride, add offsets
`default_nettype none

module palrot_addr
	import palrot_pkg::*;
#(
	parameter int SRC_WIDTH = 320
) (
	input  wire logic                   clk,
	input  wire pipe_en_t               en,
	input  wire logic [RowWidth-1:0]    src_row,
	input  wire logic [ColWidth-1:0]    src_col,
	input  wire logic [StrideWidth-1:0] stride,
	input  wire logic [MarginWidth-1:0] margin,
	output logic      [AddrWidth-1:0]   addr_s3
);

	localparam logic [AddrWidth-1:0] LastCol = AddrWidth'(SRC_WIDTH - 1);

	logic [AddrWidth-1:0]             rcol_s1;
	logic [RowWidth-1:0]              row_s1;
	logic [AddrWidth-1:0]             prod_s2;
	logic [RowSumWidth-1:0]           rowm_s2;
	logic [AddrWidth+StrideWidth-1:0] prod_full;

	assign prod_full = rcol_s1 * stride;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			rcol_s1 <= LastCol - AddrWidth'(src_col);
			row_s1  <= src_row;
		end
		if (en.en_s2) begin
			prod_s2 <= prod_full[AddrWidth-1:0];
			rowm_s2 <= RowSumWidth'(margin) + RowSumWidth'(row_s1);
		end
		if (en.en_s3) begin
			addr_s3 <= prod_s2 + AddrWidth'(rowm_s2);
		end
	end

endmodule

`default_nettype wire

FILE: design/palrot_checker.sv
// port-level checker for the palette converter, bound to the top level
`default_nettype none

`include "palette_rgb565_rotate_converter_assert.svh"

module palrot_checker
	import palrot_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  kind,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [AddrWidth-1:0]  pixel_address,
	input wire logic [ColorWidth-1:0] pixel_color
);

	// stalled result stays offered
	`PRRC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	// stalled result keeps its payload
	`PRRC_ASSERT_HOLD(a_out_stable, out_valid && !out_ready, {pixel_address, pixel_color}, "result changed while stalled")
	// input only blocks under output back pressure
	`PRRC_ASSERT(a_ready_free, !in_ready |-> out_valid && !out_ready, "input blocked without back pressure")
	// a pixel transfer reaches the output when the output is drained
	`PRRC_ASSERT(a_pixel_latency, (in_valid && in_ready && kind == KindPixel) ##1 out_ready |-> ##2 out_valid, "pixel result missing")

endmodule

bind palette_rgb565_rotate_converter palrot_checker u_palrot_checker (.*);

`default_nettype wire

FILE: tb/palrot_checker.sv
// checker for the palette converter: tracks palette and registers, predicts and compares pixels
module palrot_tb_checker
	import palrot_pkg::*;
#(
	parameter int SRC_WIDTH = 320
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     kind,
	input  logic [IndexWidth-1:0]    color_index,
	input  logic [ByteWidth-1:0]     red,
	input  logic [ByteWidth-1:0]     green,
	input  logic [ByteWidth-1:0]     blue,
	input  logic [RowWidth-1:0]      src_row,
	input  logic [ColWidth-1:0]      src_col,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [AddrWidth-1:0]     pixel_address,
	input  logic [ColorWidth-1:0]    pixel_color,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	output int                       pending,
	output int                       failures
);

	typedef struct packed {
		logic [AddrWidth-1:0]  addr;
		logic [ColorWidth-1:0] color;
	} panel_pixel_t;

	logic [ColorWidth-1:0]  palette [PaletteDepth];
	logic [StrideWidth-1:0] stride = StrideReset;
	logic [MarginWidth-1:0] margin = MarginReset;
	panel_pixel_t           awaited_pixels [$];
	int                     pixels_in  = 0;
	int                     pixels_out = 0;

	assign pending = pixels_in - pixels_out;

	initial failures = 0;

	function automatic logic [ColorWidth-1:0] pack_rgb565(input logic [ByteWidth-1:0] r,
		input logic [ByteWidth-1:0] g, input logic [ByteWidth-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// 90 degree rotation, everything wraps like a 19-bit adder
	function automatic logic [AddrWidth-1:0] rotated_address(input logic [RowWidth-1:0] row,
		input logic [ColWidth-1:0] col);
		logic [AddrWidth-1:0] flipped;
		flipped = AddrWidth'(SRC_WIDTH - 1) - AddrWidth'(col);
		return AddrWidth'(flipped * AddrWidth'(stride) + AddrWidth'(margin) + AddrWidth'(row));
	endfunction

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		panel_pixel_t head;
		if (!arst_n) begin
			awaited_pixels.delete();
			stride = StrideReset;
			margin = MarginReset;
			pixels_in  <= 0;
			pixels_out <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				RegPanelStride:  stride = cfg_data[StrideWidth-1:0];
				RegColumnMargin: margin = cfg_data[MarginWidth-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (kind == KindPalette) begin
					palette[color_index] = pack_rgb565(red, green, blue);
				end else begin
					awaited_pixels.push_back('{addr: rotated_address(src_row, src_col),
						color: palette[color_index]});
					pixels_in <= pixels_in + 1;
				end
			end
			if (out_valid && out_ready) begin
				if (awaited_pixels.size() == 0) begin
					report($sformatf("unexpected pixel transfer, address 0x%0h color 0x%0h",
						pixel_address, pixel_color));
				end else begin
					head = awaited_pixels.pop_front();
					pixels_out <= pixels_out + 1;
					if (pixel_address !== head.addr)
						report($sformatf("pixel_address 0x%0h, expected 0x%0h",
							pixel_address, head.addr));
					if (pixel_color !== head.color)
						report($sformatf("pixel_color 0x%0h, expected 0x%0h",
							pixel_color, head.color));
				end
			end
		end
	end

endmodule

FILE: tb/tb_top.sv
// testbench top: drives palette writes, pixels and register writes into the converter
module tb_top;
	import palrot_pkg::*;

	localparam int SrcWidth   = 320;
	localparam int CycleLimit = 400000;
	localparam int PhaseItems = 300;
	localparam int Phases     = 6;
	localparam int SettleGap  = 6;

	// indexes past the register list, the block must ignore them
	localparam logic [CfgIndexWidth-1:0] RegUnusedLo = 2'd2;
	localparam logic [CfgIndexWidth-1:0] RegUnusedHi = 2'd3;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic                     kind        = KindPalette;
	logic [IndexWidth-1:0]    color_index = '0;
	logic [ByteWidth-1:0]     red         = '0;
	logic [ByteWidth-1:0]     green       = '0;
	logic [ByteWidth-1:0]     blue        = '0;
	logic [RowWidth-1:0]      src_row     = '0;
	logic [ColWidth-1:0]      src_col     = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic [AddrWidth-1:0]     pixel_address;
	logic [ColorWidth-1:0]    pixel_color;
	logic                     cfg_valid   = 1'b0;
	logic                     cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index   = '0;
	logic [CfgDataWidth-1:0]  cfg_data    = '0;
	int                       pending;
	int                       failures;

	logic [IndexWidth-1:0] loaded_indices [$];
	bit                    loaded [PaletteDepth];
	logic [IndexWidth-1:0] last_loaded = '0;
	bit                    in_calm  = 1'b0;
	bit                    out_calm = 1'b0;
	int                    cycles   = 0;

	palette_rgb565_rotate_converter #(.SRC_WIDTH(SrcWidth)) dut (.*);

	palrot_tb_checker #(.SRC_WIDTH(SrcWidth)) u_checker (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_item(input logic k, input logic [IndexWidth-1:0] idx,
		input logic [ByteWidth-1:0] r, input logic [ByteWidth-1:0] g,
		input logic [ByteWidth-1:0] b, input logic [RowWidth-1:0] row,
		input logic [ColWidth-1:0] col);
		int gap;
		if ($urandom_range(0, 39) == 0)
			in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		color_index <= idx;
		red         <= r;
		green       <= g;
		blue        <= b;
		src_row     <= row;
		src_col     <= col;
		do @(posedge clk); while (!in_ready);
		if (k == KindPalette) begin
			if (!loaded[idx])
				loaded_indices.push_back(idx);
			loaded[idx] = 1'b1;
			last_loaded = idx;
		end
	endtask

	task automatic write_palette(input logic [IndexWidth-1:0] idx, input logic [ByteWidth-1:0] r,
		input logic [ByteWidth-1:0] g, input logic [ByteWidth-1:0] b);
		push_item(KindPalette, idx, r, g, b, RowWidth'($urandom), ColWidth'($urandom));
	endtask

	task automatic push_pixel(input logic [IndexWidth-1:0] idx, input logic [RowWidth-1:0] row,
		input logic [ColWidth-1:0] col);
		push_item(KindPixel, idx, ByteWidth'($urandom), ByteWidth'($urandom),
			ByteWidth'($urandom), row, col);
	endtask

	// stop sending, wait for every pixel to come out, then let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SettleGap) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
		input logic [CfgDataWidth-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [CfgDataWidth-1:0] stride_val,
		input logic [CfgDataWidth-1:0] margin_val, input bit poke_unused);
		drain();
		write_reg(RegPanelStride, stride_val);
		write_reg(RegColumnMargin, margin_val);
		if (poke_unused) begin
			write_reg(RegUnusedLo, '1);
			write_reg(RegUnusedHi, '0);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		logic [IndexWidth-1:0] idx;
		logic [RowWidth-1:0]   row;
		logic [ColWidth-1:0]   col;
		if ($urandom_range(0, 3) == 0) begin
			write_palette(IndexWidth'($urandom), ByteWidth'($urandom), ByteWidth'($urandom),
				ByteWidth'($urandom));
		end else begin
			// often read the entry just written to hit the write-then-read path
			if ($urandom_range(0, 2) == 0)
				idx = last_loaded;
			else
				idx = loaded_indices[$urandom_range(0, loaded_indices.size() - 1)];
			row = ($urandom_range(0, 7) == 0) ? RowWidth'($urandom)
				: RowWidth'($urandom_range(0, 199));
			col = ($urandom_range(0, 7) == 0) ? ColWidth'($urandom)
				: ColWidth'($urandom_range(0, SrcWidth - 1));
			push_pixel(idx, row, col);
		end
	endtask

	initial begin
		int gap;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				out_calm = !out_calm;
			gap = out_calm ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values, color extremes and packing
		write_palette(8'h00, 8'h00, 8'h00, 8'h00);
		write_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		write_palette(8'hAA, 8'h55, 8'hAA, 8'h55);
		write_palette(8'h55, 8'hAA, 8'h55, 8'hAA);
		write_palette(8'h07, 8'h07, 8'h03, 8'h07);
		write_palette(8'h08, 8'hF8, 8'hFC, 8'hF8);
		push_pixel(8'hFF, 8'd0, 9'd0);
		push_pixel(8'h00, 8'd199, 9'd319);
		push_pixel(8'hAA, 8'd255, 9'd511);
		push_pixel(8'h55, 8'hAA, 9'd320);
		push_pixel(8'h07, 8'h55, 9'h155);
		push_pixel(8'h08, 8'd100, 9'h0AA);
		write_palette(8'hFF, 8'h12, 8'h34, 8'h56);
		push_pixel(8'hFF, 8'd1, 9'd1);

		// widest registers, address overflow, masked margin bit
		configure(11'h7FF, 11'h7FF, 1'b1);
		push_pixel(8'hFF, 8'd255, 9'd0);
		push_pixel(8'h00, 8'd0, 9'd511);
		push_pixel(8'hAA, 8'd199, 9'd319);

		// zero stride folds every column onto one panel row
		configure(11'd0, 11'd0, 1'b0);
		push_pixel(8'h55, 8'd7, 9'd0);
		push_pixel(8'h08, 8'd7, 9'd319);
		push_pixel(8'h07, 8'd7, 9'd511);

		for (int phase = 0; phase < Phases; phase++) begin
			case (phase)
			0:       configure(11'd1, 11'd1023, 1'b0);
			1:       configure(11'd1024, 11'd0, 1'b1);
			2:       configure(11'd240, 11'd20, 1'b0);
			default: configure(CfgDataWidth'($urandom), CfgDataWidth'($urandom),
				1'($urandom_range(0, 1)));
			endcase
			repeat (PhaseItems) random_item();
		end

		drain();
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/palrot_pkg.sv
design/palrot_palette.sv
design/palrot_addr.sv
design/palette_rgb565_rotate_converter.sv
design/palrot_checker.sv
tb/palrot_checker.sv
tb/tb_top.sv
